FILE: hw/rtl/idts_pkg.sv
package idts_pkg;

	localparam int DW   = 32;	// Q16.16 data width
	localparam int GW   = 24;	// gamma width, unsigned Q8.16
	localparam int MW   = 43;	// divisor width (diagonal term after elimination)
	localparam int NUMW = 49;	// signed numerator width before Q16 scaling
	localparam int QW   = 32;	// quotient bits produced by the divider

	// register map, selected by paddr[2]
	localparam logic REG_GAMMA       = 1'b0;
	localparam logic REG_LINE_LENGTH = 1'b1;

	typedef struct packed {
		logic                   go;
		logic [MW-1:0]          divisor;
		logic signed [NUMW-1:0] num_cp;
		logic signed [NUMW-1:0] num_dp;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [DW-1:0] cp;
		logic signed [DW-1:0] dp;
	} div_rsp_t;

endpackage

FILE: hw/rtl/idts_div.sv
module idts_div (
	input  logic              clk,
	input  logic              arst_n,
	input  idts_pkg::div_req_t req,
	output idts_pkg::div_rsp_t rsp
);
	import idts_pkg::*;

	localparam int XW = NUMW + 17;

	typedef enum logic [1:0] {D_IDLE, D_INIT, D_RUN, D_FIN} dstate_t;

	dstate_t              st_q;
	logic [4:0]           cnt_q;
	logic                 done_q;
	logic signed [DW-1:0] cp_q, dp_q;

	logic [MW-1:0]   m_q;
	logic [NUMW-1:0] mag_q [2];
	logic            neg_q [2];
	logic            ovf_q [2];
	logic [MW-1:0]   rem_q [2];
	logic [QW-1:0]   lo_q  [2];
	logic [QW-1:0]   quo_q [2];

	logic [XW-1:0] x   [2];
	logic [MW-1:0] xhi [2];
	logic [MW:0]   sh  [2];
	logic [MW:0]   dif [2];
	logic          ge  [2];

	// round-half-away quotient magnitude -> saturated signed result
	function automatic logic signed [DW-1:0] satq(input logic ovf, input logic neg,
			input logic [QW-1:0] q);
		if (ovf) begin
			return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		if (!neg) begin
			return q[QW-1] ? 32'sh7fff_ffff : $signed(q);
		end
		if (q > 32'h8000_0000) begin
			return 32'sh8000_0000;
		end
		return $signed(~q + 32'd1);
	endfunction

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			// (|num| << 16) + m/2, upper part compared against m for overflow
			x[k]   = XW'({mag_q[k], 16'b0}) + XW'(m_q >> 1);
			xhi[k] = MW'(x[k][XW-1:QW]);
			sh[k]  = {rem_q[k], lo_q[k][QW-1]};
			dif[k] = sh[k] - {1'b0, m_q};
			ge[k]  = (sh[k] >= {1'b0, m_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
			cp_q   <= '0;
			dp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: begin
					if (req.go) begin
						st_q <= D_INIT;
					end
				end
				D_INIT: begin
					cnt_q <= '0;
					st_q  <= D_RUN;
				end
				D_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						st_q <= D_FIN;
					end
				end
				D_FIN: begin
					cp_q   <= satq(ovf_q[0], neg_q[0], quo_q[0]);
					dp_q   <= satq(ovf_q[1], neg_q[1], quo_q[1]);
					done_q <= 1'b1;
					st_q   <= D_IDLE;
				end
				default: begin
					st_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				if (req.go) begin
					m_q      <= req.divisor;
					neg_q[0] <= req.num_cp[NUMW-1];
					neg_q[1] <= req.num_dp[NUMW-1];
					mag_q[0] <= req.num_cp[NUMW-1] ? NUMW'(-req.num_cp) : NUMW'(req.num_cp);
					mag_q[1] <= req.num_dp[NUMW-1] ? NUMW'(-req.num_dp) : NUMW'(req.num_dp);
				end
			end
			D_INIT: begin
				for (int k = 0; k < 2; k++) begin
					ovf_q[k] <= (xhi[k] >= m_q);
					rem_q[k] <= xhi[k];
					lo_q[k]  <= x[k][QW-1:0];
					quo_q[k] <= '0;
				end
			end
			D_RUN: begin
				for (int k = 0; k < 2; k++) begin
					rem_q[k] <= ge[k] ? dif[k][MW-1:0] : sh[k][MW-1:0];
					lo_q[k]  <= {lo_q[k][QW-2:0], 1'b0};
					quo_q[k] <= {quo_q[k][QW-2:0], ge[k]};
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.cp   = cp_q;
	assign rsp.dp   = dp_q;

endmodule

FILE: hw/rtl/implicit_diffusion_tridiagonal_solve_top.sv
// Implicit 1D diffusion step, one line of points with reflecting ends,
// solved by forward elimination and back substitution (Thomas).
//
// Config: APB-style port, gamma at 0x0 (unsigned Q8.16), line_length
// at 0x4. pready is always high; write only while busy is low.
// Request: rhs_value (signed Q16.16) is taken on a clock edge with start
// high and busy low. Each request runs one forward step: two products on
// a shared 32x32 multiplier (skipped at point 0), then a 32-step
// restoring divider that forms the modified upper coefficient and right
// side together. That divider sets the pace: busy stays high until it is
// done, so a new request is taken only once the last step is through.
// Coefficients go to one 64-bit-wide synchronous RAM (one entry a point).
// On the last point of a line, busy stays high through back substitution:
// results come out from the last index down to 0 (RAM read, multiply,
// round and subtract), each marked by result_valid for one cycle;
// last_of_line flags point 0. The receiver cannot stall.
// Reset: gamma 0, line_length 64, point counter 0. The RAM is not
// cleared; every entry is written before back substitution reads it.
module implicit_diffusion_tridiagonal_solve_top #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] rhs_value,
	// results
	output logic               result_valid,
	output logic signed [31:0] solution_value,
	output logic [5:0]         point_index,
	output logic               last_of_line
);
	import idts_pkg::*;

	localparam int         IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam logic [6:0] MaxN = 7'(MAX_POINTS);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL1, S_MUL2, S_NUM, S_GO, S_DIV, S_BMUL, S_BOUT
	} state_t;

	// config registers
	logic [GW-1:0] gamma_q;
	logic [6:0]    line_len_q;

	// control
	state_t  state_q;
	logic [IW-1:0] pr_q;	// points received in the current line
	logic          res_valid_q;
	logic signed [DW-1:0] sol_q;
	logic [IW-1:0] idx_q;
	logic          lol_q;

	// datapath
	logic [IW-1:0]        i_q, j_q;
	logic                 last_q;
	logic signed [DW-1:0] d_q, cp_prev_q, dp_prev_q, x_q, dp_s1;
	logic signed [25:0]   a_q;
	logic [25:0]          bq_q;
	logic [MW-1:0]        m_q;
	logic signed [NUMW-1:0] ncp_q, ndp_q;
	logic signed [63:0]   prod_s1;
	logic signed [DW-1:0] op_a, op_b;

	// coefficient RAM: {cp, dp}
	logic [2*DW-1:0] mem [MAX_POINTS];
	logic [2*DW-1:0] rd_s1;
	logic [IW-1:0]   raddr;
	logic            we;

	div_req_t req;
	div_rsp_t rsp;

	logic [6:0]           n_eff;
	logic                 last_cur;
	logic signed [25:0]   neg_g, neg_2g;
	logic [25:0]          bq_now;
	logic [MW-1:0]        m_next;
	logic signed [NUMW-1:0] m_tmp, ndp_next;
	logic signed [DW-1:0] x_next;
	logic                 accept;

	function automatic logic signed [48:0] rnd16(input logic signed [63:0] p);
		logic [63:0] mag;
		logic [63:0] q;
		mag = p[63] ? 64'(-p) : 64'(p);
		q   = (mag + 64'd32768) >> 16;
		return p[63] ? -$signed(q[48:0]) : $signed(q[48:0]);
	endfunction

	function automatic logic signed [DW-1:0] sat32(input logic signed [48:0] v);
		if (v > 49'sd2147483647) begin
			return 32'sh7fff_ffff;
		end
		if (v < -49'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	//------------------------------------------------------------------
	// configuration port
	//------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q    <= '0;
			line_len_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_GAMMA:       gamma_q    <= pwdata[GW-1:0];
				REG_LINE_LENGTH: line_len_q <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GAMMA:       prdata = 32'(gamma_q);
			REG_LINE_LENGTH: prdata = 32'(line_len_q);
			default:         prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// per-request terms
	//------------------------------------------------------------------
	always_comb begin
		if (line_len_q < 7'd2) begin
			n_eff = 7'd2;
		end else if (line_len_q > MaxN) begin
			n_eff = MaxN;
		end else begin
			n_eff = line_len_q;
		end
		// a shortened line turns any point at or past n-1 into the last
		last_cur = ((7'(pr_q) + 7'd1) >= n_eff);
		neg_g    = -$signed({2'b00, gamma_q});
		neg_2g   = -$signed({1'b0, gamma_q, 1'b0});
		bq_now   = 26'd65536 + {1'b0, gamma_q, 1'b0};

		// m = b - round(cp_prev * a), held to at least one LSB
		m_tmp = $signed({23'b0, bq_q}) - rnd16(prod_s1);
		if (m_tmp < 49'sd1) begin
			m_next = MW'(1);
		end else begin
			m_next = m_tmp[MW-1:0];
		end
		ndp_next = $signed({{17{d_q[DW-1]}}, d_q}) - rnd16(prod_s1);
		x_next   = sat32($signed({{17{dp_s1[DW-1]}}, dp_s1}) - rnd16(prod_s1));
	end

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// shared multiplier operands
	always_comb begin
		case (state_q)
			S_MUL1: begin
				op_a = cp_prev_q;
				op_b = {{6{a_q[25]}}, a_q};
			end
			S_MUL2: begin
				op_a = dp_prev_q;
				op_b = {{6{a_q[25]}}, a_q};
			end
			default: begin
				op_a = rd_s1[2*DW-1:DW];
				op_b = x_q;
			end
		endcase
	end

	//------------------------------------------------------------------
	// coefficient RAM
	//------------------------------------------------------------------
	assign we    = (state_q == S_DIV) && rsp.done;
	assign raddr = (state_q == S_BOUT) ? (j_q - 1'b1) : (i_q - 1'b1);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[i_q] <= {rsp.cp, rsp.dp};
		end
		rd_s1 <= mem[raddr];
	end

	//------------------------------------------------------------------
	// divider
	//------------------------------------------------------------------
	assign req.go      = (state_q == S_GO);
	assign req.divisor = m_q;
	assign req.num_cp  = ncp_q;
	assign req.num_dp  = ndp_q;

	idts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	//------------------------------------------------------------------
	// sequencer
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pr_q        <= '0;
			res_valid_q <= 1'b0;
			sol_q       <= '0;
			idx_q       <= '0;
			lol_q       <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (pr_q == '0) ? S_GO : S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_NUM;
				S_NUM:  state_q <= S_GO;
				S_GO:   state_q <= S_DIV;
				S_DIV: begin
					if (rsp.done) begin
						if (last_q) begin
							// x(last) = dp(last)
							res_valid_q <= 1'b1;
							sol_q       <= rsp.dp;
							idx_q       <= i_q;
							lol_q       <= 1'b0;
							pr_q        <= '0;
							state_q     <= S_BMUL;
						end else begin
							pr_q    <= i_q + 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_BMUL: state_q <= S_BOUT;
				S_BOUT: begin
					res_valid_q <= 1'b1;
					sol_q       <= x_next;
					idx_q       <= j_q;
					lol_q       <= (j_q == '0);
					state_q     <= (j_q == '0) ? S_IDLE : S_BMUL;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					d_q    <= rhs_value;
					i_q    <= pr_q;
					last_q <= last_cur;
					a_q    <= last_cur ? neg_2g : neg_g;
					bq_q   <= bq_now;
					ndp_q  <= NUMW'(rhs_value);
					if (pr_q == '0) begin
						m_q   <= MW'(bq_now);
						ncp_q <= NUMW'(neg_2g);
					end else begin
						ncp_q <= NUMW'(neg_g);
					end
				end
			end
			S_MUL2: m_q   <= m_next;
			S_NUM:  ndp_q <= ndp_next;
			S_DIV: begin
				if (rsp.done) begin
					cp_prev_q <= rsp.cp;
					dp_prev_q <= rsp.dp;
					x_q       <= rsp.dp;
					j_q       <= i_q - 1'b1;
				end
			end
			S_BMUL: dp_s1 <= rd_s1[DW-1:0];
			S_BOUT: begin
				x_q <= x_next;
				j_q <= j_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign result_valid   = res_valid_q;
	assign solution_value = sol_q;
	assign point_index    = 6'(idx_q);
	assign last_of_line   = lol_q;

endmodule

FILE: hw/rtl/idts_checker.sv
module idts_props (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_valid,
	input logic [5:0] point_index,
	input logic       last_of_line
);

	// an accepted request always occupies the block: busy follows the accept
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but busy not raised");

	a_last_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_line) |-> (point_index == 6'd0))
		else $error("last_of_line on a point other than 0");

	// more results of the line still to come: block must stay busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_of_line) |-> busy)
		else $error("mid-line result while idle");

	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("results closer than two cycles");

endmodule

bind implicit_diffusion_tridiagonal_solve_top idts_props u_idts_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.point_index  (point_index),
	.last_of_line (last_of_line)
);

FILE: sim/idts_checker.sv
module idts_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] rhs_value,
	input  logic               result_valid,
	input  logic signed [31:0] solution_value,
	input  logic [5:0]         point_index,
	input  logic               last_of_line,
	output int                 fail_count,
	output int                 pending,
	output int                 lines_done,
	output int                 results_seen
);
	import idts_pkg::*;

	typedef struct {
		logic signed [31:0] value;
		logic [5:0]         idx;
		logic               last;
	} solution_t;

	solution_t expected_q[$];
	logic [23:0] gam;
	logic [6:0]  len;
	logic signed [31:0] cp_mem [64];
	logic signed [31:0] dp_mem [64];
	int pos;

	function automatic longint rdiv(longint num, longint den);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -64'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// forward step; on the last point push the back-substituted line
	task automatic solve_step(logic signed [31:0] d);
		int n, i;
		longint g, b, a, m, num, x;
		bit fin;
		solution_t s;
		n = (len < 2) ? 2 : ((len > 64) ? 64 : len);
		i = (pos > 63) ? 63 : pos;
		g = gam;
		b = 65536 + 2 * g;
		fin = (i + 1 >= n);
		if (i == 0) begin
			cp_mem[0] = clip32(rdiv(-2 * g * 65536, b));
			dp_mem[0] = clip32(rdiv(longint'(d) * 65536, b));
		end else begin
			a = fin ? -2 * g : -g;
			m = b - rdiv(longint'(cp_mem[i-1]) * a, 65536);
			if (m < 1) m = 1;
			if (!fin) cp_mem[i] = clip32(rdiv(-g * 65536, m));
			num = longint'(d) - rdiv(longint'(dp_mem[i-1]) * a, 65536);
			dp_mem[i] = clip32(rdiv(num * 65536, m));
		end
		if (!fin) begin
			pos = i + 1;
			return;
		end
		x = dp_mem[i];
		s.value = 32'(x); s.idx = 6'(i); s.last = 0;
		expected_q.push_back(s);
		while (i > 0) begin
			i--;
			x = clip32(longint'(dp_mem[i]) - rdiv(longint'(cp_mem[i]) * x, 65536));
			s.value = 32'(x); s.idx = 6'(i); s.last = (i == 0);
			expected_q.push_back(s);
		end
		pos = 0;
		lines_done++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		solution_t e;
		if (!arst_n) begin
			gam <= '0;
			len <= 7'd64;
			pos = 0;
			fail_count = 0;
			lines_done = 0;
			results_seen = 0;
			pending <= 0;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_GAMMA) gam <= pwdata[23:0];
				else len <= pwdata[6:0];
			end
			if (result_valid) begin
				results_seen++;
				if (expected_q.size() == 0) report("unexpected result", solution_value, 0);
				else begin
					e = expected_q.pop_front();
					if (solution_value !== e.value) report("solution_value", solution_value, e.value);
					if (point_index !== e.idx) report("point_index", point_index, e.idx);
					if (last_of_line !== e.last) report("last_of_line", last_of_line, e.last);
				end
			end
			if (start && !busy) solve_step(rhs_value);
			pending <= expected_q.size();
		end
	end
endmodule

FILE: sim/tb_top.sv
// Stimulus and verdict. The checker predicts every line from its own
// forward sweep and back substitution and compares each result.
module tb_top;
	import idts_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	logic signed [31:0] rhs_value = '0;
	logic result_valid;
	logic signed [31:0] solution_value;
	logic [5:0] point_index;
	logic last_of_line;
	int fail_count, pending, lines_done, results_seen;
	int quiet_cycles = 0;
	int requests_sent;

	always #4 clk = ~clk;

	implicit_diffusion_tridiagonal_solve_top DUT (.*);

	idts_checker chk (.*);

	// watchdog: cycles with no request or result accepted
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("watchdog expired");
			$display("[implicit_diffusion_tridiagonal_solve_top] ERROR");
			$finish;
		end
	end

	// only called with nothing outstanding; busy must be low too
	task automatic write_reg(logic addr_bit, logic [31:0] val);
		while (busy) @(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {addr_bit, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// hand over one sample; start stays up only until it is taken
	task automatic send_rhs(logic signed [31:0] v);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) gap = 0;
		// start drops on the previous accept edge, so rise no earlier than the next one
		repeat (gap + 1) @(posedge clk);
		start <= 1;
		rhs_value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		start <= 0;
		requests_sent++;
	endtask

	function automatic logic [31:0] pick_rhs();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(0, 8) << 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_gamma();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hFFFFFF;
			2: return $urandom_range(0, 4 << 16);
			default: return $urandom & 32'hFFFFFF;
		endcase
	endfunction

	initial begin
		int len;
		requests_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes of rhs on short lines, gamma extremes
		write_reg(REG_GAMMA, 32'h0);
		write_reg(REG_LINE_LENGTH, 32'd2);
		send_rhs(32'h7FFFFFFF); send_rhs(32'h80000000);
		drain();
		write_reg(REG_GAMMA, 32'hFFFFFF);
		send_rhs(32'h80000000); send_rhs(32'h7FFFFFFF);
		drain();
		write_reg(REG_GAMMA, 32'h10000);
		write_reg(REG_LINE_LENGTH, 32'd3);
		send_rhs(32'h00010000); send_rhs(32'hFFFFFFFF); send_rhs(32'h0);
		drain();
		// out-of-range lengths clamp
		write_reg(REG_LINE_LENGTH, 32'd0);
		send_rhs(32'h12345678); send_rhs(32'hEDCBA987);
		drain();
		write_reg(REG_LINE_LENGTH, 32'd1);
		send_rhs(32'h5555AAAA); send_rhs(32'hAAAA5555);
		drain();
		write_reg(REG_LINE_LENGTH, 32'd127);
		for (int k = 0; k < 64; k++) send_rhs(pick_rhs());
		drain();
		// length lowered mid-line, then gamma changed mid-line
		write_reg(REG_LINE_LENGTH, 32'd6);
		repeat (4) send_rhs(pick_rhs());
		drain();
		write_reg(REG_LINE_LENGTH, 32'd3);
		send_rhs(pick_rhs());
		drain();
		write_reg(REG_LINE_LENGTH, 32'd5);
		send_rhs(pick_rhs()); send_rhs(pick_rhs());
		drain();
		write_reg(REG_GAMMA, 32'h3000);
		repeat (3) send_rhs(pick_rhs());
		drain();

		// random: mostly short lines, a few full ones
		while (requests_sent < 470) begin
			len = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(2, 12);
			write_reg(REG_GAMMA, pick_gamma());
			write_reg(REG_LINE_LENGTH, 32'(len));
			repeat (len) send_rhs(pick_rhs());
			if ($urandom_range(0, 3) == 0) drain();
			else while (pending != 0) @(posedge clk);
			repeat (50) @(posedge clk);
		end

		drain();
		$display("covered %0d samples in %0d lines, %0d results checked",
			requests_sent, lines_done, results_seen);
		$display("lengths 0..127 incl. clamps, gamma 0..max, rhs extremes");
		if (fail_count == 0) $display("[implicit_diffusion_tridiagonal_solve_top] OK");
		else $display("[implicit_diffusion_tridiagonal_solve_top] ERROR");
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/idts_pkg.sv
hw/rtl/idts_div.sv
hw/rtl/implicit_diffusion_tridiagonal_solve_top.sv
hw/rtl/idts_checker.sv
sim/idts_checker.sv
sim/tb_top.sv
